// ===== rtl/line_keyword_match_scorer_macros.svh =====
// Assertion macros for the line keyword match scorer.
`ifndef LINE_KEYWORD_MATCH_SCORER_MACROS_SVH
`define LINE_KEYWORD_MATCH_SCORER_MACROS_SVH

`ifndef SYNTH
// Check cons in the same cycle as ante.
`define LKMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkms check failed");
// Check cons in the cycle after ante.
`define LKMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkms check failed");
`else
`define LKMS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LKMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/lkms_pkg.sv =====
`timescale 1ns / 1ps
package lkms_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam int WIN_DEPTH  = MAX_NEEDLE + 1;
  localparam int LEN_W      = $clog2(MAX_NEEDLE + 1);
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int SMALL_W    = 5;
  localparam logic [SMALL_W-1:0] SMALL_MAX = '1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_NEEDLE_LO  = 2'd0;
  localparam logic [1:0] REG_NEEDLE_HI  = 2'd1;
  localparam logic [1:0] REG_NEEDLE_LEN = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_US = 8'h5F;

  localparam logic [19:0] SCORE_WORD_BONUS = 20'd5;

  // One classified stream beat
  typedef struct packed {
    logic [7:0] ch;
    logic       word;
    logic       nl;
    logic       eos;
  } lkms_item_t;

  // Needle as seen by the matcher: lower-cased bytes and length
  typedef struct packed {
    logic [MAX_NEEDLE-1:0][7:0] needle;
    logic [LEN_W-1:0]           len;
  } lkms_cfg_t;

  // Queue status toward the top level
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } lkms_qstat_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CHAR_US;
  endfunction

endpackage

// ===== rtl/lkms_if.sv =====
`timescale 1ns / 1ps
interface lkms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink (input valid, data_byte, stream_end, output ready);
endinterface

interface lkms_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_no;
  logic [15:0] occurrence_count;
  logic        whole_word_hit;
  logic [19:0] match_score;

  modport source (output valid, line_no, occurrence_count, whole_word_hit, match_score,
                  input ready);
  modport sink (input valid, line_no, occurrence_count, whole_word_hit, match_score,
                output ready);
endinterface

// ===== rtl/line_keyword_match_scorer.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// stream   in   data_byte, stream_end
// report   out  line_no, occurrence_count, whole_word_hit, match_score
// apb      in   needle_bytes_low @0x00, needle_bytes_high @0x08, needle_length @0x10
//
// One beat per cycle unless a held report stalls; the 16-byte needle compare is combinational.
// report.valid rises in the cycle after a popped newline or end beat closes a line with hits.
// A four-entry queue sits between intake and matcher; stream.ready drops only when it fills.
// While a line report waits in the result register the matcher takes no beats.
// rst is synchronous and clears all control state and the needle registers.
module line_keyword_match_scorer (
  input  logic                           clk,
  input  logic                           rst,
  lkms_in_if.sink                        stream,
  lkms_out_if.source                     report,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lkms_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lkms_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import lkms_pkg::*;

`include "line_keyword_match_scorer_macros.svh"

  lkms_cfg_t   cfg;
  lkms_item_t  head;
  lkms_qstat_t qstat;
  logic        pop;

  lkms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lkms_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  lkms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .report     (report)
  );

  `LKMS_ASSERT_NOW(a_pop_not_empty, clk, rst, pop, !qstat.empty)
  `LKMS_ASSERT_NOW(a_full_blocks, clk, rst, qstat.full, !stream.ready)
  `LKMS_ASSERT_NOW(a_report_has_hits, clk, rst, report.valid, report.occurrence_count != 16'd0)
  `LKMS_ASSERT_NEXT(a_full_holds, clk, rst, qstat.full && !pop, qstat.full)

endmodule

// ===== rtl/lkms_cfg.sv =====
`timescale 1ns / 1ps
module lkms_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lkms_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lkms_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output lkms_pkg::lkms_cfg_t            cfg
);
  import lkms_pkg::*;

  logic [63:0]      needle_lo;
  logic [63:0]      needle_hi;
  logic [LEN_W-1:0] needle_len;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_lo  <= '0;
      needle_hi  <= '0;
      needle_len <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NEEDLE_LO:  needle_lo  <= pwdata;
        REG_NEEDLE_HI:  needle_hi  <= pwdata;
        REG_NEEDLE_LEN: needle_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back raw register values
  always_comb begin
    unique case (reg_idx)
      REG_NEEDLE_LO:  prdata = needle_lo;
      REG_NEEDLE_HI:  prdata = needle_hi;
      REG_NEEDLE_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, needle_len};
      default:        prdata = '0;
    endcase
  end

  // Lower-case the needle for the matcher
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cfg.needle[k]     = lower_ascii(needle_lo[k*8 +: 8]);
      cfg.needle[k + 8] = lower_ascii(needle_hi[k*8 +: 8]);
    end
    cfg.len = needle_len;
  end

endmodule

// ===== rtl/lkms_front.sv =====
`timescale 1ns / 1ps
module lkms_front (
  input  logic                  clk,
  input  logic                  rst,
  lkms_in_if.sink               stream,
  input  logic                  pop,
  output lkms_pkg::lkms_item_t  head,
  output lkms_pkg::lkms_qstat_t qstat
);
  import lkms_pkg::*;

  lkms_item_t        mem [QDEPTH];
  lkms_item_t        item;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // Classify the incoming beat
  always_comb begin
    item.ch   = lower_ascii(stream.data_byte);
    item.word = is_word(stream.data_byte);
    item.nl   = stream.data_byte == CHAR_NL;
    item.eos  = stream.stream_end;
  end

  assign qstat.count = count;
  assign qstat.full  = count == QCNT_W'(QDEPTH);
  assign qstat.empty = count == '0;
  assign stream.ready = !qstat.full;
  assign push = stream.valid && stream.ready;
  assign head = mem[rd_ptr];

  // Store classified beats
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/lkms_back.sv =====
`timescale 1ns / 1ps
module lkms_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lkms_pkg::lkms_cfg_t  cfg,
  input  lkms_pkg::lkms_item_t head,
  input  logic                 head_valid,
  output logic                 pop,
  lkms_out_if.source           report
);
  import lkms_pkg::*;

  // Line state
  logic [WIN_DEPTH-1:0][7:0] window, window_next;
  logic [SMALL_W-1:0]        bytes_in_line, bytes_in_line_next;
  logic [SMALL_W-1:0]        since_match, since_match_next;
  logic                      pending, pending_next;
  logic [15:0]               hit_count, hit_count_next;
  logic                      wws, wws_next;
  logic [31:0]               line_counter, line_counter_next;
  logic                      line_nonempty, line_nonempty_next;

  // Result register
  logic        out_valid;
  logic [31:0] res_line;
  logic [15:0] res_count;
  logic        res_whole;
  logic [19:0] res_score;

  // Match datapath
  logic [MAX_NEEDLE-1:0][7:0] aligned;
  logic [MAX_NEEDLE-1:0]      eq;
  logic [LEN_W-1:0]           len;
  logic                       len_ok;
  logic                       match;
  logic                       left_ok;
  logic [LEN_W-1:0]           nidx;
  logic                       do_finish;
  logic                       emit;
  logic                       fin_whole;
  logic [31:0]                fin_line;
  logic [19:0]                cnt_ext;

  assign len    = cfg.len;
  assign len_ok = len != '0 && len <= LEN_W'(MAX_NEEDLE);
  assign pop    = head_valid && (!out_valid || report.ready);

  // Line up needle so its last byte faces the newest window byte
  always_comb begin
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      nidx       = len - LEN_W'(1) - LEN_W'(k);
      aligned[k] = cfg.needle[nidx[LEN_W-2:0]];
    end
  end

  // Step the line state for one beat
  always_comb begin
    window_next        = window;
    bytes_in_line_next = bytes_in_line;
    since_match_next   = since_match;
    pending_next       = pending;
    hit_count_next     = hit_count;
    wws_next           = wws;
    line_counter_next  = line_counter;
    line_nonempty_next = line_nonempty;
    eq                 = '0;
    match              = 1'b0;
    left_ok            = 1'b0;
    do_finish          = 1'b0;

    window_next[0] = head.ch;
    for (int k = 1; k < WIN_DEPTH; k++) window_next[k] = window[k-1];
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      eq[k] = (LEN_W'(k) >= len) || (window_next[k] == aligned[k]);
    end

    if (head.eos) begin
      do_finish = line_nonempty;
    end else if (head.nl) begin
      do_finish = 1'b1;
    end else begin
      if (pending && !head.word) wws_next = 1'b1;
      pending_next = 1'b0;
      if (bytes_in_line != SMALL_MAX) bytes_in_line_next = bytes_in_line + 1'b1;
      if (since_match != SMALL_MAX)   since_match_next   = since_match + 1'b1;
      line_nonempty_next = 1'b1;
      match = len_ok && (bytes_in_line_next >= SMALL_W'(len)) &&
              (since_match_next >= SMALL_W'(len)) && (&eq);
      left_ok = (bytes_in_line_next == SMALL_W'(len)) ||
                !is_word(window_next[WIN_IDX_W'(len)]);
      if (match) begin
        if (hit_count != 16'hFFFF) hit_count_next = hit_count + 1'b1;
        since_match_next = '0;
        if (left_ok) pending_next = 1'b1;
      end
    end

    fin_whole = wws || pending;
    fin_line  = (line_counter != 32'hFFFF_FFFF) ? line_counter + 1'b1 : line_counter;
    emit      = do_finish && hit_count != '0;

    // Clear the line on newline or end of stream
    if (head.eos || head.nl) begin
      bytes_in_line_next = '0;
      since_match_next   = SMALL_MAX;
      pending_next       = 1'b0;
      hit_count_next     = '0;
      wws_next           = 1'b0;
      line_nonempty_next = 1'b0;
      line_counter_next  = head.eos ? '0 : fin_line;
    end
  end

  assign cnt_ext = {4'b0, hit_count};

  // Commit the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      since_match   <= SMALL_MAX;
      pending       <= 1'b0;
      hit_count     <= '0;
      wws           <= 1'b0;
      line_counter  <= '0;
      line_nonempty <= 1'b0;
    end else if (pop) begin
      bytes_in_line <= bytes_in_line_next;
      since_match   <= since_match_next;
      pending       <= pending_next;
      hit_count     <= hit_count_next;
      wws           <= wws_next;
      line_counter  <= line_counter_next;
      line_nonempty <= line_nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.eos && !head.nl) window <= window_next;
  end

  // Hold a finished line until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_line  <= fin_line;
      res_count <= hit_count;
      res_whole <= fin_whole;
      res_score <= (cnt_ext << 3) + (cnt_ext << 1) + (fin_whole ? SCORE_WORD_BONUS : '0);
    end
  end

  assign report.valid            = out_valid;
  assign report.line_no          = res_line;
  assign report.occurrence_count = res_count;
  assign report.whole_word_hit   = res_whole;
  assign report.match_score      = res_score;

endmodule
